// ----- hdl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the linear gradient sampler.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int MAX_STOPS   = 8;
    localparam int IDX_W       = $clog2(MAX_STOPS);
    localparam int CNT_W       = $clog2(MAX_STOPS + 1);
    localparam int T_FRAC_BITS = 16;
    localparam int POS_W       = 17;
    localparam int COLOR_W     = 32;
    localparam int CH_W        = 8;
    localparam int NUM_CH      = 4;
    localparam int COORD_W     = 16;
    localparam int REL_W       = COORD_W + 1;
    localparam int PROD_W      = REL_W + 32;
    localparam int T_W         = PROD_W + 2;
    localparam int NUM_W       = CH_W + POS_W;
    localparam int DOWN_SHIFT  = (T_FRAC_BITS >= 16) ? T_FRAC_BITS - 16 : 0;
    localparam int UP_SHIFT    = (T_FRAC_BITS < 16) ? 16 - T_FRAC_BITS : 0;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = CH_W / DIV_BITS;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic signed [T_W-1:0] T_ONE = T_W'(1) <<< T_FRAC_BITS;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_T_START      = 3'd0,
        REG_T_STEP_X     = 3'd1,
        REG_T_STEP_Y     = 3'd2,
        REG_ORIGIN_X     = 3'd3,
        REG_ORIGIN_Y     = 3'd4,
        REG_STOPS_IN_USE = 3'd5,
        REG_BRUSH_VALID  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0]        t_start;
        logic signed [31:0]        step_x;
        logic signed [31:0]        step_y;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [CNT_W-1:0]          stops_in_use;
        logic                      brush_valid;
    } cfg_t;

    // one request moving down the pipeline
    typedef struct packed {
        logic                      is_sample;
        logic [IDX_W-1:0]          stop_index;
        logic [POS_W-1:0]          stop_position;
        logic [COLOR_W-1:0]        stop_color;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [COLOR_W-1:0] color;
    } stop_t;

    // result of the stop search
    typedef struct packed {
        logic             is_sample;
        logic             zero;
        logic             solid;
        logic [POS_W-1:0] tq;
    } sel_t;

endpackage

// ----- hdl/lgs_t_calc.sv -----
// ----------------------------------------------------------------------------
// lgs_t_calc
// Three-stage gradient parameter path: offset, multiply, sum and clamp.
// ----------------------------------------------------------------------------
module lgs_t_calc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lgs_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    input  lgs_pkg::item_t       in_item,
    output logic                 out_valid,
    output lgs_pkg::item_t       out_item,
    output logic [lgs_pkg::POS_W-1:0] out_tq
);

    logic [2:0]                           vld_reg;
    lgs_pkg::item_t                       item1_reg, item2_reg, item3_reg;
    logic signed [lgs_pkg::REL_W-1:0]     rel_x_reg, rel_y_reg;
    logic signed [lgs_pkg::REL_W-1:0]     rel_x_next, rel_y_next;
    logic signed [lgs_pkg::PROD_W-1:0]    prod_x_reg, prod_y_reg;
    logic signed [lgs_pkg::T_W-1:0]       t_sum;
    logic signed [lgs_pkg::T_W-1:0]       t_clamp;
    logic [lgs_pkg::POS_W-1:0]            tq_reg, tq_next;

    // offset coordinates against the rectangle origin
    assign rel_x_next = lgs_pkg::REL_W'(in_item.pixel_x) - lgs_pkg::REL_W'(cfg.origin_x);
    assign rel_y_next = lgs_pkg::REL_W'(in_item.pixel_y) - lgs_pkg::REL_W'(cfg.origin_y);

    // sum the terms and clamp to 0 .. 1.0
    always_comb begin
        t_sum = lgs_pkg::T_W'(cfg.t_start) + lgs_pkg::T_W'(prod_x_reg)
              + lgs_pkg::T_W'(prod_y_reg);
        if (t_sum < 0) begin
            t_clamp = '0;
        end else if (t_sum > lgs_pkg::T_ONE) begin
            t_clamp = lgs_pkg::T_ONE;
        end else begin
            t_clamp = t_sum;
        end
        tq_next = lgs_pkg::POS_W'((t_clamp >>> lgs_pkg::DOWN_SHIFT) <<< lgs_pkg::UP_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item1_reg  <= in_item;
            rel_x_reg  <= rel_x_next;
            rel_y_reg  <= rel_y_next;
            item2_reg  <= item1_reg;
            prod_x_reg <= rel_x_reg * cfg.step_x;
            prod_y_reg <= rel_y_reg * cfg.step_y;
            item3_reg  <= item2_reg;
            tq_reg     <= tq_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_item  = item3_reg;
    assign out_tq    = tq_reg;

endmodule

// ----- hdl/lgs_stop_table.sv -----
// ----------------------------------------------------------------------------
// lgs_stop_table
// Stop storage, enclosing-pair search and registered read of the pair.
// ----------------------------------------------------------------------------
module lgs_stop_table (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  lgs_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    input  lgs_pkg::item_t            in_item,
    input  logic [lgs_pkg::POS_W-1:0] in_tq,
    output logic                      out_valid,
    output lgs_pkg::sel_t             out_sel,
    output lgs_pkg::stop_t            out_lo,
    output lgs_pkg::stop_t            out_hi
);

    logic [lgs_pkg::POS_W-1:0]   pos_reg [lgs_pkg::MAX_STOPS];
    lgs_pkg::stop_t              mem_lo [lgs_pkg::MAX_STOPS];
    lgs_pkg::stop_t              mem_hi [lgs_pkg::MAX_STOPS];
    logic [lgs_pkg::MAX_STOPS-1:0] lt;
    logic [lgs_pkg::CNT_W-1:0]   n;
    logic [lgs_pkg::CNT_W-1:0]   n_m1, n_m2;
    logic [lgs_pkg::IDX_W-1:0]   lo_idx, hi_idx;
    logic                        zero, solid, wr_en;
    logic                        vld_reg;
    lgs_pkg::sel_t               sel_reg;
    lgs_pkg::stop_t              lo_reg, hi_reg;

    assign wr_en = en && in_valid && !in_item.is_sample;

    // compare t against every stored position
    always_comb begin
        for (int k = 0; k < lgs_pkg::MAX_STOPS; k++) begin
            lt[k] = in_tq < pos_reg[k];
        end
    end

    // clamp the stop count and pick the pair
    always_comb begin
        if (cfg.stops_in_use > lgs_pkg::CNT_W'(lgs_pkg::MAX_STOPS)) begin
            n = lgs_pkg::CNT_W'(lgs_pkg::MAX_STOPS);
        end else begin
            n = cfg.stops_in_use;
        end
        n_m1  = n - lgs_pkg::CNT_W'(1);
        n_m2  = n - lgs_pkg::CNT_W'(2);
        zero  = !cfg.brush_valid || (n == '0);
        solid = 1'b1;
        lo_idx = '0;
        priority if (zero) begin
            lo_idx = '0;
        end else if (in_tq <= pos_reg[0]) begin
            lo_idx = '0;
        end else if (!lt[n_m1[lgs_pkg::IDX_W-1:0]]) begin
            lo_idx = n_m1[lgs_pkg::IDX_W-1:0];
        end else begin
            solid  = 1'b0;
            lo_idx = n_m2[lgs_pkg::IDX_W-1:0];
            // smallest slot whose upper neighbor lies above t wins
            for (int k = lgs_pkg::MAX_STOPS - 2; k >= 0; k--) begin
                if ((k + 2 < int'(n)) && lt[k+1]) begin
                    lo_idx = lgs_pkg::IDX_W'(k);
                end
            end
        end
        hi_idx = lo_idx + lgs_pkg::IDX_W'(1);
    end

    // store stops; reads happen in the same stage so order is kept
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_reg[in_item.stop_index] <= in_item.stop_position;
            mem_lo[in_item.stop_index]  <= {in_item.stop_position, in_item.stop_color};
            mem_hi[in_item.stop_index]  <= {in_item.stop_position, in_item.stop_color};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg  <= mem_lo[lo_idx];
            hi_reg  <= mem_hi[hi_idx];
            sel_reg <= '{is_sample: in_item.is_sample, zero: zero, solid: solid, tq: in_tq};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    assign out_valid = vld_reg;
    assign out_sel   = sel_reg;
    assign out_lo    = lo_reg;
    assign out_hi    = hi_reg;

endmodule

// ----- hdl/lgs_lerp.sv -----
// ----------------------------------------------------------------------------
// lgs_lerp
// Per-channel weighting and pipelined restoring division by the pair width.
// ----------------------------------------------------------------------------
module lgs_lerp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  lgs_pkg::sel_t               in_sel,
    input  lgs_pkg::stop_t              in_lo,
    input  lgs_pkg::stop_t              in_hi,
    output logic                        out_valid,
    output logic [lgs_pkg::COLOR_W-1:0] out_color
);

    localparam int REM_W = lgs_pkg::NUM_W + 1;

    typedef struct packed {
        logic                        is_sample;
        logic                        flat;
        logic [lgs_pkg::COLOR_W-1:0] flat_color;
        logic [lgs_pkg::POS_W-1:0]   r;
    } ctl_t;

    typedef logic [lgs_pkg::NUM_W-1:0] num_arr_t [lgs_pkg::NUM_CH];
    typedef logic [lgs_pkg::CH_W-1:0]  q_arr_t   [lgs_pkg::NUM_CH];

    logic [lgs_pkg::DIV_STAGES+1:0] vld_reg;
    ctl_t                           ctl1_reg, ctl2_reg;
    ctl_t                           dctl_reg [lgs_pkg::DIV_STAGES];
    logic [lgs_pkg::POS_W-1:0]      d_reg, rd_reg;
    logic [lgs_pkg::COLOR_W-1:0]    c0_reg, c1_reg;
    ctl_t                           ctl1_next;
    logic [lgs_pkg::POS_W-1:0]      d_next;
    num_arr_t                       num_reg;
    num_arr_t                       rem_reg  [lgs_pkg::DIV_STAGES];
    q_arr_t                         q_reg    [lgs_pkg::DIV_STAGES];
    num_arr_t                       rem_next [lgs_pkg::DIV_STAGES];
    q_arr_t                         q_next   [lgs_pkg::DIV_STAGES];
    logic [lgs_pkg::COLOR_W-1:0]    div_color;

    // pair width, offset into the pair and the flat cases
    always_comb begin
        ctl1_next.is_sample = in_sel.is_sample;
        ctl1_next.flat      = in_sel.zero || in_sel.solid || (in_hi.pos <= in_lo.pos);
        ctl1_next.flat_color = in_sel.zero ? '0 : in_lo.color;
        ctl1_next.r         = in_hi.pos - in_lo.pos;
        d_next              = in_sel.tq - in_lo.pos;
    end

    // divide two quotient bits per stage, from the top bit down
    always_comb begin
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dv;
        logic [lgs_pkg::CH_W-1:0] q;
        int bitpos;
        for (int s = 0; s < lgs_pkg::DIV_STAGES; s++) begin
            for (int c = 0; c < lgs_pkg::NUM_CH; c++) begin
                if (s == 0) begin
                    rem = REM_W'(num_reg[c]);
                    q   = '0;
                end else begin
                    rem = REM_W'(rem_reg[s-1][c]);
                    q   = q_reg[s-1][c];
                end
                for (int b = 0; b < lgs_pkg::DIV_BITS; b++) begin
                    bitpos = lgs_pkg::CH_W - 1 - s * lgs_pkg::DIV_BITS - b;
                    dv = REM_W'((s == 0) ? ctl2_reg.r : dctl_reg[s-1].r) << bitpos;
                    if (rem >= dv) begin
                        rem = rem - dv;
                        q[bitpos] = 1'b1;
                    end
                end
                rem_next[s][c] = lgs_pkg::NUM_W'(rem);
                q_next[s][c]   = q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl1_reg <= ctl1_next;
            d_reg    <= d_next;
            rd_reg   <= ctl1_next.r - d_next;
            c0_reg   <= in_lo.color;
            c1_reg   <= in_hi.color;
            ctl2_reg <= ctl1_reg;
            // weight both ends of the pair
            for (int c = 0; c < lgs_pkg::NUM_CH; c++) begin
                num_reg[c] <= lgs_pkg::NUM_W'(
                    c0_reg[lgs_pkg::COLOR_W-1-c*lgs_pkg::CH_W -: lgs_pkg::CH_W] * rd_reg
                  + c1_reg[lgs_pkg::COLOR_W-1-c*lgs_pkg::CH_W -: lgs_pkg::CH_W] * d_reg);
            end
            for (int s = 0; s < lgs_pkg::DIV_STAGES; s++) begin
                dctl_reg[s] <= (s == 0) ? ctl2_reg : dctl_reg[s-1];
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[lgs_pkg::DIV_STAGES:0], in_valid};
        end
    end

    // alpha lands in the top byte like the stored colors
    always_comb begin
        for (int c = 0; c < lgs_pkg::NUM_CH; c++) begin
            div_color[lgs_pkg::COLOR_W-1-c*lgs_pkg::CH_W -: lgs_pkg::CH_W] =
                q_reg[lgs_pkg::DIV_STAGES-1][c];
        end
    end

    assign out_valid = vld_reg[lgs_pkg::DIV_STAGES+1]
                       && dctl_reg[lgs_pkg::DIV_STAGES-1].is_sample;
    assign out_color = dctl_reg[lgs_pkg::DIV_STAGES-1].flat
                       ? dctl_reg[lgs_pkg::DIV_STAGES-1].flat_color : div_color;

endmodule

// ----- hdl/linear_gradient_sampler.sv -----
// ----------------------------------------------------------------------------
// linear_gradient_sampler
// Linear gradient shader with an eight-entry stop table and ARGB output.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries requests: s_tuser is the mode (0 writes a stop into
//   the table, 1 samples a pixel). A stop write yields no result; a sample
//   yields one ARGB result on the m_ channel.
//   The user must write registers over cfg_we/cfg_addr/cfg_wdata only while
//   idle; the block does not enforce it. Throughput: one request per cycle
//   while the receiver does not stall. Stage chain to m_tvalid: input
//   register (loaded at the accepting edge), three t stages (offset,
//   multiply, sum/clamp), one stop search and table read, two weighting
//   stages, four divide stages (two quotient bits each), output register.
//   When the receiver stalls the whole pipeline holds and s_tready drops;
//   nothing is lost or repeated.
//   Reset clears all valid bits and the config registers; the stop table keeps
//   no reset and each slot must be written before a sample can select it.
// ----------------------------------------------------------------------------
module linear_gradient_sampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // stop_index[2:0], stop_position[19:3], stop_color[51:20],
    // pixel_x[67:52], pixel_y[83:68], zero fill [87:84]
    input  logic [87:0] s_tdata,
    // mode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // alpha[7:0], red[15:8], green[23:16], blue[31:24]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                        en;
    lgs_pkg::cfg_t               cfg_reg;
    logic                        in_vld_reg;
    lgs_pkg::item_t              in_item_reg, in_item_next;
    logic                        t_valid;
    lgs_pkg::item_t              t_item;
    logic [lgs_pkg::POS_W-1:0]   t_tq;
    logic                        s_valid;
    lgs_pkg::sel_t               s_sel;
    lgs_pkg::stop_t              s_lo, s_hi;
    logic                        l_valid;
    logic [lgs_pkg::COLOR_W-1:0] l_color;
    logic                        m_vld_reg;
    logic [31:0]                 m_data_reg;

    // advance whenever the output slot is free or being taken
    assign en       = !m_vld_reg || m_tready;
    assign s_tready = en;

    assign in_item_next = '{
        is_sample:     s_tuser[0],
        stop_index:    s_tdata[2:0],
        stop_position: s_tdata[19:3],
        stop_color:    s_tdata[51:20],
        pixel_x:       s_tdata[67:52],
        pixel_y:       s_tdata[83:68]
    };

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lgs_pkg::REG_T_START:      cfg_reg.t_start <= cfg_wdata;
                lgs_pkg::REG_T_STEP_X:     cfg_reg.step_x <= cfg_wdata;
                lgs_pkg::REG_T_STEP_Y:     cfg_reg.step_y <= cfg_wdata;
                lgs_pkg::REG_ORIGIN_X:     cfg_reg.origin_x <= cfg_wdata[lgs_pkg::COORD_W-1:0];
                lgs_pkg::REG_ORIGIN_Y:     cfg_reg.origin_y <= cfg_wdata[lgs_pkg::COORD_W-1:0];
                lgs_pkg::REG_STOPS_IN_USE: cfg_reg.stops_in_use <= cfg_wdata[lgs_pkg::CNT_W-1:0];
                lgs_pkg::REG_BRUSH_VALID:  cfg_reg.brush_valid <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_item_reg <= in_item_next;
        end
    end

    lgs_t_calc u_t_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (in_vld_reg),
        .in_item   (in_item_reg),
        .out_valid (t_valid),
        .out_item  (t_item),
        .out_tq    (t_tq)
    );

    lgs_stop_table u_stop_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (t_valid),
        .in_item   (t_item),
        .in_tq     (t_tq),
        .out_valid (s_valid),
        .out_sel   (s_sel),
        .out_lo    (s_lo),
        .out_hi    (s_hi)
    );

    lgs_lerp u_lerp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_sel    (s_sel),
        .in_lo     (s_lo),
        .in_hi     (s_hi),
        .out_valid (l_valid),
        .out_color (l_color)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= l_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {l_color[7:0], l_color[15:8], l_color[23:16], l_color[31:24]};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while output stalled");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(l_valid) && (!l_valid || $stable(l_color)))
        else $error("pipeline moved during stall");
`endif

endmodule
